/* rtl/core/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// Best-fit allocator package
// Shared constants and operation codes for the best-fit block allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

    // Default table shape.
    localparam int DEF_NUM_BLOCKS = 16;
    localparam int DEF_SIZE_BITS  = 16;

    // Fixed widths of the transaction fields.
    localparam int OP_W   = 1;
    localparam int BIDX_W = 4;
    localparam int REQ_W  = 16;
    localparam int FRAG_W = 16;
    localparam int CFG_W  = 5;

    // Reset value of the blocks-in-use register.
    localparam logic [CFG_W-1:0] BIU_RESET = CFG_W'(16);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
    localparam logic [OP_W-1:0] OP_ALLOC = 1'b1;

endpackage

/* rtl/core/best_fit_block_allocator_top.sv */
// ----------------------------------------------------------------------------
// Best-fit block allocator
// Table of block sizes with used marks; grants the smallest free block that
// fits a request, scanning the table through a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a rising edge where i_start is high and o_busy
//   is low. i_op selects a load (write i_size into slot i_block_index and
//   mark it free) or an allocate (i_size is the requested size).
//   Every transaction gives one result, shown for exactly one cycle with
//   o_valid high: o_found, o_granted_block and o_fragment. Loads and misses
//   report all zero.
//   A load completes at once: its result appears in the cycle after it is
//   taken and o_busy stays low, so loads may follow back to back.
//   An allocate sends one scan token down the chain of NUM_BLOCKS cells, one
//   cell per cycle; its result appears once the token has passed the launch
//   register, every cell and the result register, and o_busy is high until then.
//   So no new transaction is taken while an allocate's scan is in flight.
//   The next transaction can be taken in the cycle that shows the result.
//   i_cfg_we writes i_cfg_wdata into the blocks-in-use register; only the
//   first that many slots take part. Write it while the block is idle.
//   Reset clears all used marks and the scan, and sets blocks-in-use to
//   sixteen; block sizes must be loaded before they are allocated.
//   The receiver cannot stall: each result is taken in the cycle it shows.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_top
    import bfa_pkg::*;
#(
    parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
    parameter int SIZE_BITS  = DEF_SIZE_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [OP_W-1:0]   i_op,
    input  logic [BIDX_W-1:0] i_block_index,
    input  logic [REQ_W-1:0]  i_size,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    output logic              o_valid,
    output logic              o_found,
    output logic [BIDX_W-1:0] o_granted_block,
    output logic [FRAG_W-1:0] o_fragment
);

    localparam int IDX_W  = $clog2(NUM_BLOCKS);
    localparam int CW     = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;
    localparam int SCAN_W = 2 + IDX_W + SIZE_BITS;

    typedef struct packed {
        logic                 tok;
        logic                 have;
        logic [IDX_W-1:0]     idx;
        logic [SIZE_BITS-1:0] size;
    } t_scan;

    logic [CFG_W-1:0]           r_biu;
    logic                       r_busy;
    logic                       r_launch;
    logic [CW-1:0]              r_req;
    logic                       r_valid;
    logic                       r_found;
    logic [BIDX_W-1:0]          r_gblk;
    logic [FRAG_W-1:0]          r_frag;

    logic                       w_acc;
    logic                       w_load;
    logic                       w_alloc;
    logic [REQ_W+SIZE_BITS-1:0] w_wr_wide;
    logic [SIZE_BITS-1:0]       w_wr_size;
    logic [REQ_W+CW-1:0]        w_req_wide;
    t_scan                      w_last;
    logic                       w_done;
    logic                       w_grant;
    logic [IDX_W+BIDX_W-1:0]    w_gblk_wide;
    logic [CW+SIZE_BITS-1:0]    w_best_wide;
    logic [CW-1:0]              w_diff;
    logic [NUM_BLOCKS-1:0]      w_tok_vec;
    logic [SCAN_W-1:0]          w_chain [NUM_BLOCKS+1];

    // Transaction decode.
    assign w_acc   = i_start && !r_busy;
    assign w_load  = w_acc && (i_op == OP_LOAD);
    assign w_alloc = w_acc && (i_op == OP_ALLOC);

    assign w_wr_wide  = {{SIZE_BITS{1'b0}}, i_size};
    assign w_wr_size  = w_wr_wide[SIZE_BITS-1:0];
    assign w_req_wide = {{CW{1'b0}}, i_size};

    // Head of the chain: an empty candidate carrying the launch token.
    assign w_chain[0] = SCAN_W'({r_launch, 1'b0, {IDX_W{1'b0}}, {SIZE_BITS{1'b0}}});

    // Chain of cells.
    for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
        t_scan w_out;

        bfa_cell #(
            .NUM_BLOCKS (NUM_BLOCKS),
            .SIZE_BITS  (SIZE_BITS),
            .CELL_IDX   (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr_en    (w_load && (32'(i_block_index) == g)),
            .i_wr_size  (w_wr_size),
            .i_set_used (w_grant && (32'(w_last.idx) == g)),
            .i_in_use   (g < 32'(r_biu)),
            .i_req      (r_req),
            .i_scan     (w_chain[g]),
            .o_scan     (w_chain[g+1])
        );

        assign w_out        = t_scan'(w_chain[g+1]);
        assign w_tok_vec[g] = w_out.tok;
    end

    // Tail of the chain: final candidate and grant.
    assign w_last      = t_scan'(w_chain[NUM_BLOCKS]);
    assign w_done      = w_last.tok;
    assign w_grant     = w_done && w_last.have;
    assign w_gblk_wide = {{BIDX_W{1'b0}}, w_last.idx};
    assign w_best_wide = {{CW{1'b0}}, w_last.size};
    assign w_diff      = w_best_wide[CW-1:0] - r_req;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_biu <= BIU_RESET;
        end else if (i_cfg_we) begin
            r_biu <= i_cfg_wdata;
        end
    end

    // Scan control: busy from an allocate until its token leaves the chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_launch <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_launch <= w_alloc;
            r_valid  <= w_load || w_done;
            if (w_alloc) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Request size held for the scan.
    always_ff @(posedge i_clk) begin
        if (w_alloc) begin
            r_req <= w_req_wide[CW-1:0];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_grant) begin
            r_found <= 1'b1;
            r_gblk  <= w_gblk_wide[BIDX_W-1:0];
            r_frag  <= w_diff[FRAG_W-1:0];
        end else begin
            r_found <= 1'b0;
            r_gblk  <= '0;
            r_frag  <= '0;
        end
    end

    assign o_busy          = r_busy;
    assign o_valid         = r_valid;
    assign o_found         = r_found;
    assign o_granted_block = r_gblk;
    assign o_fragment      = r_frag;

    // While busy exactly one token is in flight, and none otherwise.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> $onehot({w_tok_vec, r_launch}))
        else $error("scan token count wrong while busy");

    a_no_token_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> ({w_tok_vec, r_launch} == '0))
        else $error("scan token present while idle");

    // An accepted allocate makes the block busy.
    a_alloc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alloc |=> r_busy)
        else $error("allocate did not start a scan");

    // A grant only ever follows the end of a scan.
    a_found_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_found) |-> $past(w_done))
        else $error("grant reported without a completed scan");

endmodule

/* rtl/core/bfa_cell.sv */
// ----------------------------------------------------------------------------
// Best-fit allocator cell
// Holds one block size and its used mark, and refines the best-fit candidate
// that passes through the chain one cell per cycle.
// ----------------------------------------------------------------------------
module bfa_cell
    import bfa_pkg::*;
#(
    parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
    parameter int SIZE_BITS  = DEF_SIZE_BITS,
    parameter int CELL_IDX   = 0,
    localparam int IDX_W     = $clog2(NUM_BLOCKS),
    localparam int CW        = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W,
    localparam int SCAN_W    = 2 + IDX_W + SIZE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [SIZE_BITS-1:0] i_wr_size,
    input  logic                 i_set_used,
    input  logic                 i_in_use,
    input  logic [CW-1:0]        i_req,
    input  logic [SCAN_W-1:0]    i_scan,
    output logic [SCAN_W-1:0]    o_scan
);

    typedef struct packed {
        logic                 tok;
        logic                 have;
        logic [IDX_W-1:0]     idx;
        logic [SIZE_BITS-1:0] size;
    } t_scan;

    logic [SIZE_BITS-1:0]    r_size;
    logic                    r_used;
    t_scan                   w_in;
    t_scan                   n_scan;
    t_scan                   r_scan;
    logic [CW+SIZE_BITS-1:0] w_size_wide;
    logic [CW-1:0]           w_size_ext;
    logic                    w_take;

    assign w_in        = t_scan'(i_scan);
    assign w_size_wide = {{CW{1'b0}}, r_size};
    assign w_size_ext  = w_size_wide[CW-1:0];

    // This block wins if it takes part, is free, large enough and strictly smaller than
    // the candidate so far; a tie keeps the earlier, lower index.
    assign w_take = i_in_use && !r_used && (w_size_ext >= i_req)
                    && (!w_in.have || (r_size < w_in.size));

    always_comb begin
        n_scan = w_in;
        if (w_take) begin
            n_scan.have = 1'b1;
            n_scan.idx  = IDX_W'(CELL_IDX);
            n_scan.size = r_size;
        end
    end

    // Block size and used mark.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_wr_en) begin
            r_used <= 1'b0;
        end else if (i_set_used) begin
            r_used <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_size <= i_wr_size;
        end
    end

    // Travelling scan: token and candidate handed on every cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else begin
            r_scan <= n_scan;
        end
    end

    assign o_scan = r_scan;

endmodule
